>>> src/msg_pkg.sv
// ============================================================================
// msg_pkg
// Shared widths, mode codes, command constants and sine table math for the
// motion setpoint generator.
// ============================================================================
`default_nettype none

package msg_pkg;

    localparam int MODE_W  = 8;
    localparam int TICK_W  = 20;
    localparam int CMD_W   = 16;
    localparam int PITCH_W = 14;
    localparam int TIME_W  = 24;
    localparam int SINE_W  = 15;
    localparam int AMP_W   = 14;

    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam logic [MODE_W-1:0] MODE_CIRCLE    = 8'd1;
    localparam logic [MODE_W-1:0] MODE_FIG8_4S   = 8'd2;
    localparam logic [MODE_W-1:0] MODE_FIG8_6S   = 8'd3;
    localparam logic [MODE_W-1:0] MODE_FIG8_3S   = 8'd4;
    localparam logic [MODE_W-1:0] MODE_SPIN      = 8'd5;
    localparam logic [MODE_W-1:0] MODE_STOP_GO   = 8'd6;
    localparam logic [MODE_W-1:0] MODE_SQUARE    = 8'd7;
    localparam logic [MODE_W-1:0] MODE_SLALOM    = 8'd8;
    localparam logic [MODE_W-1:0] MODE_PITCH_UP  = 8'd9;
    localparam logic [MODE_W-1:0] MODE_PITCH_DN  = 8'd10;
    localparam logic [MODE_W-1:0] MODE_PITCH_OSC = 8'd11;

    localparam logic signed [CMD_W-1:0]   THR_ON      = 16'sd9830;
    localparam logic signed [CMD_W-1:0]   TURN_CIRCLE = 16'sd6554;
    localparam logic signed [CMD_W-1:0]   TURN_SPIN   = 16'sd11469;
    localparam logic signed [PITCH_W-1:0] PITCH_5DEG  = 14'sd5719;

    localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;
    localparam logic [TIME_W-1:0] T_1_0S   = 24'd1000000;
    localparam logic [TIME_W-1:0] T_1_5S   = 24'd1500000;
    localparam logic [TIME_W-1:0] T_2_5S   = 24'd2500000;
    localparam logic [TIME_W-1:0] T_3_0S   = 24'd3000000;
    localparam logic [TIME_W-1:0] T_4_0S   = 24'd4000000;
    localparam logic [TIME_W-1:0] T_4_5S   = 24'd4500000;
    localparam logic [TIME_W-1:0] T_5_5S   = 24'd5500000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // period of the mode in microseconds, zero for non-periodic modes
    function automatic logic [TIME_W-1:0] period_of(input logic [MODE_W-1:0] mode);
        logic [TIME_W-1:0] p;
        unique case (mode)
            MODE_FIG8_4S:   p = 24'd4000000;
            MODE_FIG8_6S:   p = 24'd6000000;
            MODE_FIG8_3S:   p = 24'd3000000;
            MODE_STOP_GO:   p = 24'd2000000;
            MODE_SQUARE:    p = 24'd6000000;
            MODE_SLALOM:    p = 24'd3000000;
            MODE_PITCH_OSC: p = 24'd10000000;
            default:        p = '0;
        endcase
        return p;
    endfunction

    function automatic logic uses_sine(input logic [MODE_W-1:0] mode);
        logic s;
        unique case (mode)
            MODE_FIG8_4S, MODE_FIG8_6S, MODE_FIG8_3S,
            MODE_SLALOM, MODE_PITCH_OSC: s = 1'b1;
            default:                     s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [AMP_W-1:0] sine_amp(input logic [MODE_W-1:0] mode);
        logic [AMP_W-1:0] a;
        unique case (mode)
            MODE_FIG8_4S:   a = 14'd8192;
            MODE_FIG8_6S:   a = 14'd6554;
            MODE_FIG8_3S:   a = 14'd9830;
            MODE_SLALOM:    a = 14'd13107;
            MODE_PITCH_OSC: a = 14'd3431;
            default:        a = '0;
        endcase
        return a;
    endfunction

    // Q15 table entry from a Q30 angle, Taylor series through x^17
    function automatic logic [SINE_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        rnd = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        return rnd[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/msg_in_if.sv
// ============================================================================
// msg_in_if
// Tick channel: mode number and elapsed microseconds with valid/ready.
// ============================================================================
`default_nettype none

interface msg_in_if;
    logic                        valid;
    logic                        ready;
    logic [msg_pkg::MODE_W-1:0]  mode;
    logic [msg_pkg::TICK_W-1:0]  tick_us;

    modport source (output valid, mode, tick_us, input ready);
    modport sink   (input valid, mode, tick_us, output ready);
endinterface

`default_nettype wire

>>> src/msg_out_if.sv
// ============================================================================
// msg_out_if
// Setpoint channel: throttle, turn and target pitch with valid/ready.
// ============================================================================
`default_nettype none

interface msg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [msg_pkg::CMD_W-1:0]    throttle;
    logic signed [msg_pkg::CMD_W-1:0]    turn;
    logic signed [msg_pkg::PITCH_W-1:0]  target_pitch;

    modport source (output valid, throttle, turn, target_pitch, input ready);
    modport sink   (input valid, throttle, turn, target_pitch, output ready);
endinterface

`default_nettype wire

>>> src/msg_sine_rom.sv
// ============================================================================
// msg_sine_rom
// Quarter-wave sine table, SINE_TABLE_DEPTH+1 entries, registered read.
// ============================================================================
`default_nettype none

module msg_sine_rom #(
    parameter int SINE_TABLE_DEPTH = msg_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic [IW-1:0]               i_addr,
    output logic      [msg_pkg::SINE_W-1:0]  o_data
);

    localparam logic [63:0] DEPTH_U64 = 64'(SINE_TABLE_DEPTH);

    logic [msg_pkg::SINE_W-1:0] w_tab [0:SINE_TABLE_DEPTH];
    logic [msg_pkg::SINE_W-1:0] r_data;

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
        assign w_tab[k] = msg_pkg::sine_q15((64'(k) * msg_pkg::HALF_PI_Q30) / DEPTH_U64);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> src/motion_setpoint_generator.sv
// ============================================================================
// motion_setpoint_generator
// Per-tick throttle, turn and pitch setpoints for a set of motion patterns.
// ============================================================================
// Constant and piecewise modes go from accept to S_OUT, which loads the output
// once it is free. Sine modes pass S_MUL, S_DIV, S_IDX, S_ROM, S_SCALE, S_OUT: one
//   multiply, QW restoring divide steps (QW = clog2(4*SINE_TABLE_DEPTH), 10 at 256),
//   index, table read, scale, load. Ready only while the sequencer is idle, so a new
//   tick waits until the last item is loaded, longer while the output item is held.
// Reset: synchronous active-low; clears elapsed time, previous mode, state.
`default_nettype none

module motion_setpoint_generator #(
    parameter int SINE_TABLE_DEPTH = msg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    msg_in_if.sink     i_tick,
    msg_out_if.source  o_setpt
);

    localparam int QW = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int CW = $clog2(QW);
    localparam int TW = msg_pkg::TIME_W;
    localparam int NW = TW + QW;
    localparam int PW = TW + msg_pkg::SINE_W;

    localparam logic [msg_pkg::SINE_W-1:0] FOUR_D = msg_pkg::SINE_W'(4 * SINE_TABLE_DEPTH);
    localparam logic [QW-1:0] D1 = QW'(SINE_TABLE_DEPTH);
    localparam logic [QW-1:0] D2 = QW'(2 * SINE_TABLE_DEPTH);
    localparam logic [QW-1:0] D3 = QW'(3 * SINE_TABLE_DEPTH);
    localparam logic [IW-1:0] DI = IW'(SINE_TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_IDX,
        S_ROM,
        S_SCALE,
        S_OUT
    } t_state;

    t_state                            r_state;
    logic [TW-1:0]                     r_elapsed;
    logic [msg_pkg::MODE_W-1:0]        r_prev_mode;
    logic [msg_pkg::MODE_W-1:0]        r_mode;
    logic [TW-1:0]                     r_t;
    logic [NW-1:0]                     r_num;
    logic [NW-1:0]                     r_div;
    logic [QW-1:0]                     r_q;
    logic [CW-1:0]                     r_cnt;
    logic [IW-1:0]                     r_idx;
    logic                              r_neg;
    logic signed [msg_pkg::CMD_W-1:0]  r_sval;
    logic                              r_out_valid;
    logic signed [msg_pkg::CMD_W-1:0]  r_thr;
    logic signed [msg_pkg::CMD_W-1:0]  r_turn;
    logic signed [msg_pkg::PITCH_W-1:0] r_pitch;

    logic [TW-1:0]                     n_elapsed;
    logic [TW-1:0]                     w_t_cur;
    logic [TW:0]                       w_sum;
    logic [TW-1:0]                     w_period_in;
    logic                              w_accept;
    logic [TW-1:0]                     w_mul_a;
    logic [msg_pkg::SINE_W-1:0]        w_mul_b;
    logic [PW-1:0]                     w_prod;
    logic [PW-1:0]                     w_rnd;
    logic [msg_pkg::CMD_W-1:0]         w_mag;
    logic                              w_ge;
    logic [QW-1:0]                     w_base;
    logic [1:0]                        w_quad;
    logic [QW-1:0]                     w_rem;
    logic [msg_pkg::SINE_W-1:0]        w_sine;
    logic                              w_out_free;
    logic                              w_drive;
    logic signed [msg_pkg::CMD_W-1:0]  n_thr;
    logic signed [msg_pkg::CMD_W-1:0]  n_turn;
    logic signed [msg_pkg::PITCH_W-1:0] n_pitch;

    assign w_accept    = i_tick.valid && i_tick.ready;
    assign i_tick.ready = (r_state == S_IDLE);

    // time bookkeeping at accept
    assign w_t_cur     = (i_tick.mode != r_prev_mode) ? '0 : r_elapsed;
    assign w_period_in = msg_pkg::period_of(i_tick.mode);
    assign w_sum       = {1'b0, w_t_cur} + (TW + 1)'(i_tick.tick_us);

    always_comb begin
        if (w_period_in != '0) begin
            if (w_sum >= {1'b0, w_period_in}) begin
                n_elapsed = TW'(w_sum - {1'b0, w_period_in});
            end else begin
                n_elapsed = w_sum[TW-1:0];
            end
        end else if (w_sum[TW]) begin
            n_elapsed = msg_pkg::TIME_MAX;
        end else begin
            n_elapsed = w_sum[TW-1:0];
        end
    end

    // shared multiplier: phase numerator, then amplitude scaling
    assign w_mul_a = (r_state == S_MUL) ? r_t : TW'(w_sine);
    assign w_mul_b = (r_state == S_MUL) ? FOUR_D
                                        : msg_pkg::SINE_W'(msg_pkg::sine_amp(r_mode));
    assign w_prod  = PW'(w_mul_a) * PW'(w_mul_b);
    assign w_rnd   = w_prod + PW'(16384);
    assign w_mag   = {1'b0, w_rnd[29:15]};

    assign w_ge = (r_num >= r_div);

    // quadrant split of the phase index
    always_comb begin
        if (r_q >= D3) begin
            w_quad = 2'd3;
            w_base = D3;
        end else if (r_q >= D2) begin
            w_quad = 2'd2;
            w_base = D2;
        end else if (r_q >= D1) begin
            w_quad = 2'd1;
            w_base = D1;
        end else begin
            w_quad = 2'd0;
            w_base = '0;
        end
        w_rem = r_q - w_base;
    end

    msg_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (w_sine)
    );

    // result selection
    assign w_drive = (r_t < msg_pkg::T_1_0S)
                  || (r_t >= msg_pkg::T_1_5S && r_t < msg_pkg::T_2_5S)
                  || (r_t >= msg_pkg::T_3_0S && r_t < msg_pkg::T_4_0S)
                  || (r_t >= msg_pkg::T_4_5S && r_t < msg_pkg::T_5_5S);

    always_comb begin
        n_thr   = '0;
        n_turn  = '0;
        n_pitch = '0;
        unique case (r_mode)
            msg_pkg::MODE_CIRCLE: begin
                n_thr  = msg_pkg::THR_ON;
                n_turn = msg_pkg::TURN_CIRCLE;
            end
            msg_pkg::MODE_FIG8_4S, msg_pkg::MODE_FIG8_6S,
            msg_pkg::MODE_FIG8_3S, msg_pkg::MODE_SLALOM: begin
                n_thr  = msg_pkg::THR_ON;
                n_turn = r_sval;
            end
            msg_pkg::MODE_SPIN: begin
                n_turn = msg_pkg::TURN_SPIN;
            end
            msg_pkg::MODE_STOP_GO: begin
                n_thr = (r_t < msg_pkg::T_1_0S) ? msg_pkg::THR_ON : '0;
            end
            msg_pkg::MODE_SQUARE: begin
                if (w_drive) begin
                    n_thr = msg_pkg::THR_ON;
                end else begin
                    n_turn = msg_pkg::TURN_SPIN;
                end
            end
            msg_pkg::MODE_PITCH_UP: begin
                n_pitch = msg_pkg::PITCH_5DEG;
            end
            msg_pkg::MODE_PITCH_DN: begin
                n_pitch = -msg_pkg::PITCH_5DEG;
            end
            msg_pkg::MODE_PITCH_OSC: begin
                n_pitch = r_sval[msg_pkg::PITCH_W-1:0];
            end
            default: begin
                n_thr = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || o_setpt.ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_prev_mode <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a load in S_OUT sets valid itself
            if (r_out_valid && o_setpt.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode      <= i_tick.mode;
                        r_t         <= w_t_cur;
                        r_elapsed   <= n_elapsed;
                        r_prev_mode <= i_tick.mode;
                        r_state     <= msg_pkg::uses_sine(i_tick.mode) ? S_MUL : S_OUT;
                    end
                end
                S_MUL: begin
                    r_num   <= w_prod[NW-1:0];
                    r_div   <= NW'({msg_pkg::period_of(r_mode), {(QW-1){1'b0}}});
                    r_cnt   <= CW'(QW - 1);
                    r_q     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_num <= r_num - r_div;
                    end
                    r_q   <= {r_q[QW-2:0], w_ge};
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_idx   <= w_quad[0] ? (DI - w_rem[IW-1:0]) : w_rem[IW-1:0];
                    r_neg   <= w_quad[1];
                    r_state <= S_ROM;
                end
                S_ROM: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_sval  <= r_neg ? $signed(16'd0 - w_mag) : $signed(w_mag);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_thr       <= n_thr;
                        r_turn      <= n_turn;
                        r_pitch     <= n_pitch;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_setpt.valid        = r_out_valid;
    assign o_setpt.throttle     = r_thr;
    assign o_setpt.turn         = r_turn;
    assign o_setpt.target_pitch = r_pitch;

    a_time_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_period_in != '0) |=> (r_elapsed < $past(w_period_in)))
        else $error("elapsed time left the mode period");

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDX) |-> (QW'(r_q) < FOUR_D))
        else $error("phase index beyond four quadrants");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_setpt.ready) |=> (r_state == S_OUT))
        else $error("result loaded over an untaken item");

    a_pitch_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_setpt.valid |-> (o_setpt.target_pitch == '0
                           || (o_setpt.throttle == '0 && o_setpt.turn == '0)))
        else $error("pitch and drive commands given together");

endmodule

`default_nettype wire

>>> bench/setpoint_checker.sv
// ============================================================================
// setpoint_checker
// Watches the tick and setpoint channels of the motion setpoint generator.
// Predicts throttle, turn and target pitch for each accepted tick from its
// own copy of the elapsed time, previous mode and quarter-wave sine table,
// then compares every accepted setpoint item in order, field by field.
// ============================================================================

module setpoint_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    msg_in_if    i_tick,
    msg_out_if   i_setpt,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = msg_pkg::SINE_TABLE_DEPTH_DEF;

    localparam logic [23:0] PERIOD_2S  = 24'd2000000;
    localparam logic [23:0] PERIOD_3S  = 24'd3000000;
    localparam logic [23:0] PERIOD_4S  = 24'd4000000;
    localparam logic [23:0] PERIOD_6S  = 24'd6000000;
    localparam logic [23:0] PERIOD_10S = 24'd10000000;

    localparam int AMP_FIG8_4S   = 8192;
    localparam int AMP_FIG8_6S   = 6554;
    localparam int AMP_FIG8_3S   = 9830;
    localparam int AMP_SLALOM    = 13107;
    localparam int AMP_PITCH_OSC = 3431;

    typedef struct packed {
        logic signed [15:0] throttle;
        logic signed [15:0] turn;
        logic signed [13:0] target_pitch;
    } setpt_t;

    logic [14:0] quarter_sine [0:DEPTH];
    logic [23:0] run_time;
    logic [7:0]  seen_mode;
    setpt_t      expected_setpts [$];
    int          mismatches;

    // Q15 quarter wave from a Taylor series in Q30, terms through x^17
    initial begin : build_sine
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        rounded;
        logic signed [63:0] acc;
        for (int k = 0; k <= DEPTH; k++) begin
            x    = (64'(k) * 64'd1686629713) / 64'(DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            acc  = $signed(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
            end
            if (acc < 0) begin
                acc = '0;
            end
            if (acc > 64'sd1073741824) begin
                acc = 64'sd1073741824;
            end
            rounded = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
            quarter_sine[k] = rounded[14:0];
        end
    end

    function automatic int sine_of(input logic [23:0] t, input logic [23:0] period);
        logic [63:0] phase;
        logic [63:0] quad;
        logic [63:0] idx;
        phase = (64'(t) * 64'(4 * DEPTH)) / 64'(period);
        phase = phase % 64'(4 * DEPTH);
        quad  = phase / 64'(DEPTH);
        idx   = phase % 64'(DEPTH);
        case (quad[1:0])
            2'd0:    return int'(quarter_sine[idx]);
            2'd1:    return int'(quarter_sine[64'(DEPTH) - idx]);
            2'd2:    return -int'(quarter_sine[idx]);
            default: return -int'(quarter_sine[64'(DEPTH) - idx]);
        endcase
    endfunction

    // amplitude * sine / 2^15, rounded half away from zero
    function automatic int scaled(input int amp, input int s);
        int mag;
        int v;
        mag = (s < 0) ? -s : s;
        v   = (amp * mag + 16384) >>> 15;
        return (s < 0) ? -v : v;
    endfunction

    function automatic setpt_t predict_setpt(input logic [7:0] mode, input logic [19:0] dt);
        logic [23:0] t;
        logic [23:0] period;
        logic [24:0] next_time;
        int          thr;
        int          trn;
        int          pit;
        setpt_t      sp;
        if (mode != seen_mode) begin
            run_time  = '0;
            seen_mode = mode;
        end
        t      = run_time;
        period = '0;
        thr    = 0;
        trn    = 0;
        pit    = 0;
        case (mode)
            msg_pkg::MODE_CIRCLE: begin
                thr = msg_pkg::THR_ON;
                trn = msg_pkg::TURN_CIRCLE;
            end
            msg_pkg::MODE_FIG8_4S: begin
                period = PERIOD_4S;
                thr    = msg_pkg::THR_ON;
                trn    = scaled(AMP_FIG8_4S, sine_of(t, period));
            end
            msg_pkg::MODE_FIG8_6S: begin
                period = PERIOD_6S;
                thr    = msg_pkg::THR_ON;
                trn    = scaled(AMP_FIG8_6S, sine_of(t, period));
            end
            msg_pkg::MODE_FIG8_3S: begin
                period = PERIOD_3S;
                thr    = msg_pkg::THR_ON;
                trn    = scaled(AMP_FIG8_3S, sine_of(t, period));
            end
            msg_pkg::MODE_SPIN: begin
                trn = msg_pkg::TURN_SPIN;
            end
            msg_pkg::MODE_STOP_GO: begin
                period = PERIOD_2S;
                thr    = (t < msg_pkg::T_1_0S) ? int'(msg_pkg::THR_ON) : 0;
            end
            msg_pkg::MODE_SQUARE: begin
                period = PERIOD_6S;
                if (t < msg_pkg::T_1_0S
                        || (t >= msg_pkg::T_1_5S && t < msg_pkg::T_2_5S)
                        || (t >= msg_pkg::T_3_0S && t < msg_pkg::T_4_0S)
                        || (t >= msg_pkg::T_4_5S && t < msg_pkg::T_5_5S)) begin
                    thr = msg_pkg::THR_ON;
                end else begin
                    trn = msg_pkg::TURN_SPIN;
                end
            end
            msg_pkg::MODE_SLALOM: begin
                period = PERIOD_3S;
                thr    = msg_pkg::THR_ON;
                trn    = scaled(AMP_SLALOM, sine_of(t, period));
            end
            msg_pkg::MODE_PITCH_UP: begin
                pit = msg_pkg::PITCH_5DEG;
            end
            msg_pkg::MODE_PITCH_DN: begin
                pit = -int'(msg_pkg::PITCH_5DEG);
            end
            msg_pkg::MODE_PITCH_OSC: begin
                period = PERIOD_10S;
                pit    = scaled(AMP_PITCH_OSC, sine_of(t, period));
            end
            default: begin
            end
        endcase

        next_time = {1'b0, t} + 25'(dt);
        if (period != '0) begin
            if (next_time >= 25'(period)) begin
                next_time = next_time - 25'(period);
            end
        end else if (next_time > 25'(msg_pkg::TIME_MAX)) begin
            next_time = 25'(msg_pkg::TIME_MAX);
        end
        run_time = next_time[23:0];

        sp.throttle     = thr[15:0];
        sp.turn         = trn[15:0];
        sp.target_pitch = pit[13:0];
        return sp;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        setpt_t got;
        setpt_t want;
        if (!i_rst_n) begin
            run_time   = '0;
            seen_mode  = '0;
            mismatches = 0;
            expected_setpts.delete();
        end else begin
            if (i_tick.valid && i_tick.ready) begin
                expected_setpts.push_back(predict_setpt(i_tick.mode, i_tick.tick_us));
            end
            if (i_setpt.valid && i_setpt.ready) begin
                got.throttle     = i_setpt.throttle;
                got.turn         = i_setpt.turn;
                got.target_pitch = i_setpt.target_pitch;
                if (expected_setpts.size() == 0) begin
                    $error("setpoint item with none expected: throttle %0d turn %0d pitch %0d",
                           got.throttle, got.turn, got.target_pitch);
                    mismatches++;
                end else begin
                    want = expected_setpts.pop_front();
                    compare_field("throttle", want.throttle, got.throttle);
                    compare_field("turn", want.turn, got.turn);
                    compare_field("target_pitch", want.target_pitch, got.target_pitch);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_setpts.size();
    end

endmodule

>>> bench/tb_top.sv
// ============================================================================
// tb_top
// Drives control ticks into the motion setpoint generator: a directed pass
// over every mode, quadrant edges and time wrap, then random runs of ticks
// per mode with mixed step sizes. Both handshake sides idle at random, and
// the setpoint side holds off for long stretches to back up the block.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_COUNT = 550;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_OFF   = 400;
    localparam int DRAIN      = 40;

    localparam logic [7:0]  MODE_STOP     = 8'd0;
    localparam logic [7:0]  MODE_UNUSED   = 8'd12;
    localparam logic [7:0]  MODE_TOP      = 8'd255;
    localparam logic [19:0] DT_MAX        = 20'd1000000;
    localparam logic [19:0] DT_HALF       = 20'd500000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   ticks_sent;
    int   results_taken;
    logic burst;

    msg_in_if  tick_ch ();
    msg_out_if setpt_ch ();

    motion_setpoint_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch),
        .o_setpt (setpt_ch)
    );

    setpoint_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_setpt      (setpt_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_tick(input logic [7:0] mode, input logic [19:0] dt);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.mode    <= mode;
        tick_ch.tick_us <= dt;
        do @(posedge i_clk); while (!(tick_ch.valid && tick_ch.ready));
        ticks_sent++;
    endtask

    function automatic logic [19:0] draw_dt(input int style);
        case (style)
            0:       return 20'($urandom_range(0, 1000000));
            1:       return 20'($urandom_range(0, 4) * 250000);
            2:       return 20'($urandom_range(0, 2000));
            default: return 20'($urandom_range(999000, 1000000));
        endcase
    endfunction

    initial begin : stimulus
        logic [7:0] seg_mode;
        int         seg_len;
        int         style;
        tick_ch.valid   <= 1'b0;
        tick_ch.mode    <= '0;
        tick_ch.tick_us <= '0;
        i_rst_n         <= 1'b0;
        ticks_sent = 0;
        burst      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(MODE_STOP, '0);
        send_tick(msg_pkg::MODE_CIRCLE, DT_MAX);
        // quadrant edges then exact wrap back to zero
        repeat (5) send_tick(msg_pkg::MODE_FIG8_4S, DT_MAX);
        repeat (2) send_tick(msg_pkg::MODE_FIG8_6S, DT_MAX);
        send_tick(msg_pkg::MODE_FIG8_3S, DT_HALF);
        send_tick(msg_pkg::MODE_SPIN, DT_MAX);
        repeat (3) send_tick(msg_pkg::MODE_STOP_GO, DT_MAX);
        repeat (2) send_tick(msg_pkg::MODE_SQUARE, DT_MAX);
        send_tick(msg_pkg::MODE_SLALOM, DT_MAX);
        send_tick(msg_pkg::MODE_PITCH_UP, DT_MAX);
        send_tick(msg_pkg::MODE_PITCH_DN, '0);
        repeat (2) send_tick(msg_pkg::MODE_PITCH_OSC, DT_MAX);
        send_tick(MODE_UNUSED, DT_MAX);
        send_tick(MODE_TOP, DT_MAX);

        while (ticks_sent < TICK_COUNT) begin
            case ($urandom_range(0, 9))
                0:       seg_mode = MODE_STOP;
                1:       seg_mode = 8'($urandom_range(MODE_UNUSED, MODE_TOP));
                default: seg_mode = 8'($urandom_range(msg_pkg::MODE_CIRCLE,
                                                      msg_pkg::MODE_PITCH_OSC));
            endcase
            seg_len = $urandom_range(1, 30);
            style   = $urandom_range(0, 3);
            burst   = ($urandom_range(0, 3) == 0);
            repeat (seg_len) send_tick(seg_mode, draw_dt(style));
        end
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : setpoint_sink
        int stall;
        setpt_ch.ready <= 1'b0;
        results_taken = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 3);
            if ((results_taken / 40) % 3 == 0) begin
                stall = 0;
            end
            // long hold-off so the block fills and stalls its tick input
            if (results_taken == 120 || results_taken == 380) begin
                stall = HOLD_OFF;
            end
            if (stall > 0) begin
                setpt_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            setpt_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(setpt_ch.valid && setpt_ch.ready));
            results_taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((tick_ch.valid && tick_ch.ready) || (setpt_ch.valid && setpt_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
